// ===== hdl/trs_pkg.sv =====
// shared constants of the trs model matrix block: cordic table, gain, beat widths
// no dependencies
package trs_pkg;

    localparam int TDATA_IN_W  = 240;
    localparam int TDATA_OUT_W = 384;
    localparam int ATAN_LEN    = 24;

    // cordic gain 0.60725... in q30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef logic [31:0] atan_tab_t [0:ATAN_LEN-1];

    // atan(2^-i) in 2^-32 turns
    localparam atan_tab_t ATAN_TURNS32 = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== hdl/trs_model_matrix.sv =====
// trs model matrix: pipelined cordic sin/cos, rotation product, scale and saturation
// depends on trs_pkg
//
// channel   dir  handshake           payload
// s_axis    in   s_tvalid/s_tready   s_tdata: pos x,y,z, angle x,y,z, scale x,y,z
// m_axis    out  m_tvalid/m_tready   m_tdata: col0..col2 rows 0..2, trans x,y,z
//
// one beat per cycle sustained while m_tready stays high; stages in order:
// input register, one cordic step per stage, quadrant/round, three product
// stages, scale multiply, round/saturate output register
// aresetn is synchronous; it clears only the stage valid bits
// each stage holds while the one after it is full and stalled; empty stages
// fill, so input beats keep entering while a result waits on m_tready
module trs_model_matrix #(
    parameter int FRAC_BITS    = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int SINCOS_STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z (32 each), angle_x, angle_y, angle_z (16 each),
    // scale_x, scale_y, scale_z (32 each)
    input  logic [trs_pkg::TDATA_IN_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // col0_row0..2, col1_row0..2, col2_row0..2, trans_x, trans_y, trans_z
    // (32 each)
    output logic [trs_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import trs_pkg::*;

    localparam int S   = SINCOS_STEPS;
    localparam int SQ  = S + 1;   // quadrant fold and rounding
    localparam int SA  = S + 2;   // first products
    localparam int SB  = S + 3;   // second-level products
    localparam int SC  = S + 4;   // rotation entries
    localparam int SD  = S + 5;   // scale multiply
    localparam int SE  = S + 6;   // round, saturate, output
    localparam int L   = S + 7;
    localparam int RW  = FRAC_BITS + 4;
    localparam int SH  = 30 - FRAC_BITS;
    localparam int MW  = RW + 32;

    localparam logic signed [33:0]     RND_CS = 34'sd1 <<< (SH - 1);
    localparam logic signed [2*RW-1:0] RND_M  = (2*RW)'(1) << (FRAC_BITS - 1);
    localparam logic signed [MW-1:0]   RND_S  = MW'(1) << (FRAC_BITS - 1);
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    function automatic logic signed [RW-1:0] rm(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
        logic signed [2*RW-1:0] p;
        p = (2*RW)'(a) * (2*RW)'(b);
        p = p + RND_M;
        return RW'(p >>> FRAC_BITS);
    endfunction

    // stage valid bits and advance chain
    logic [L-1:0] vld_reg;
    logic [L:0]   adv;

    always_comb begin
        adv[L] = m_tready;
        for (int k = L - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[SE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < L; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // position and scale ride along with the stages
    logic signed [31:0] pos_reg   [0:L-1][0:2];
    logic signed [31:0] scale_reg [0:L-1][0:2];

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int a = 0; a < 3; a++) begin
                pos_reg[0][a]   <= s_tdata[32*a +: 32];
                scale_reg[0][a] <= s_tdata[144 + 32*a +: 32];
            end
        end
        for (int k = 1; k < L; k++) begin
            if (adv[k]) begin
                pos_reg[k]   <= pos_reg[k-1];
                scale_reg[k] <= scale_reg[k-1];
            end
        end
    end

    // cordic: stage 0 loads the start vector, stage i+1 does step i
    logic signed [33:0] x_reg [0:S][0:2];
    logic signed [33:0] y_reg [0:S][0:2];
    logic signed [31:0] z_reg [0:S][0:2];
    logic [1:0]         q_reg [0:S][0:2];
    logic [31:0]        turn  [0:2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            turn[a] = (32'(s_tdata[96 + 16*a +: 16]) & AMASK) << (32 - ANGLE_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int a = 0; a < 3; a++) begin
                x_reg[0][a] <= CORDIC_GAIN_Q30;
                y_reg[0][a] <= '0;
                z_reg[0][a] <= {2'b00, turn[a][29:0]};
                q_reg[0][a] <= turn[a][31:30];
            end
        end
        for (int i = 0; i < S; i++) begin
            if (adv[i+1]) begin
                for (int a = 0; a < 3; a++) begin
                    q_reg[i+1][a] <= q_reg[i][a];
                    if (!z_reg[i][a][31]) begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - $signed(ATAN_TURNS32[i]);
                    end else begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + $signed(ATAN_TURNS32[i]);
                    end
                end
            end
        end
    end

    // quadrant fold and rounding to the working fraction
    logic signed [RW-1:0] cos_reg [0:2];
    logic signed [RW-1:0] sin_reg [0:2];
    logic signed [33:0]   cf [0:2];
    logic signed [33:0]   sf [0:2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            case (q_reg[S][a])
                2'd0: begin
                    cf[a] = x_reg[S][a];
                    sf[a] = y_reg[S][a];
                end
                2'd1: begin
                    cf[a] = -y_reg[S][a];
                    sf[a] = x_reg[S][a];
                end
                2'd2: begin
                    cf[a] = -x_reg[S][a];
                    sf[a] = -y_reg[S][a];
                end
                default: begin
                    cf[a] = y_reg[S][a];
                    sf[a] = -x_reg[S][a];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[SQ]) begin
            for (int a = 0; a < 3; a++) begin
                cos_reg[a] <= RW'((cf[a] + RND_CS) >>> SH);
                sin_reg[a] <= RW'((sf[a] + RND_CS) >>> SH);
            end
        end
    end

    // first products
    // 0 sxsy, 1 cxsy, 2 cycz, 3 cysz, 4 cxsz, 5 cxcz, 6 sxcy, 7 sxsz,
    // 8 sxcz, 9 cxcy, 10 sy, 11 cz, 12 sz
    logic signed [RW-1:0] a_reg [0:12];

    always_ff @(posedge aclk) begin
        if (adv[SA]) begin
            a_reg[0]  <= rm(sin_reg[0], sin_reg[1]);
            a_reg[1]  <= rm(cos_reg[0], sin_reg[1]);
            a_reg[2]  <= rm(cos_reg[1], cos_reg[2]);
            a_reg[3]  <= rm(cos_reg[1], sin_reg[2]);
            a_reg[4]  <= rm(cos_reg[0], sin_reg[2]);
            a_reg[5]  <= rm(cos_reg[0], cos_reg[2]);
            a_reg[6]  <= rm(sin_reg[0], cos_reg[1]);
            a_reg[7]  <= rm(sin_reg[0], sin_reg[2]);
            a_reg[8]  <= rm(sin_reg[0], cos_reg[2]);
            a_reg[9]  <= rm(cos_reg[0], cos_reg[1]);
            a_reg[10] <= sin_reg[1];
            a_reg[11] <= cos_reg[2];
            a_reg[12] <= sin_reg[2];
        end
    end

    // second-level products; slots 2..10 pass through, slots 0, 1, 11, 12
    // become sxsy*cz, sxsy*sz, cxsy*cz, cxsy*sz
    logic signed [RW-1:0] b_reg [0:12];

    always_ff @(posedge aclk) begin
        if (adv[SB]) begin
            for (int k = 2; k < 11; k++) begin
                b_reg[k] <= a_reg[k];
            end
            b_reg[0]  <= rm(a_reg[0], a_reg[11]);
            b_reg[1]  <= rm(a_reg[0], a_reg[12]);
            b_reg[11] <= rm(a_reg[1], a_reg[11]);
            b_reg[12] <= rm(a_reg[1], a_reg[12]);
        end
    end

    // rotation entries in column-major output order
    logic signed [RW-1:0] r_reg [0:8];

    always_ff @(posedge aclk) begin
        if (adv[SC]) begin
            r_reg[0] <= b_reg[2];
            r_reg[1] <= b_reg[4] + b_reg[0];
            r_reg[2] <= b_reg[7] - b_reg[11];
            r_reg[3] <= -b_reg[3];
            r_reg[4] <= b_reg[5] - b_reg[1];
            r_reg[5] <= b_reg[8] + b_reg[12];
            r_reg[6] <= b_reg[10];
            r_reg[7] <= -b_reg[6];
            r_reg[8] <= b_reg[9];
        end
    end

    // scale multiply, column j by scale j
    logic signed [MW-1:0] m_reg [0:8];

    always_ff @(posedge aclk) begin
        if (adv[SD]) begin
            for (int e = 0; e < 9; e++) begin
                m_reg[e] <= MW'(r_reg[e]) * MW'(scale_reg[SC][e/3]);
            end
        end
    end

    // round half up and saturate to 32 bits
    logic [31:0]          out_reg [0:8];
    logic signed [MW-1:0] rs [0:8];

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            rs[e] = (m_reg[e] + RND_S) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[SE]) begin
            for (int e = 0; e < 9; e++) begin
                if ((&rs[e][MW-1:31]) || !(|rs[e][MW-1:31])) begin
                    out_reg[e] <= rs[e][31:0];
                end else if (rs[e][MW-1]) begin
                    out_reg[e] <= 32'h8000_0000;
                end else begin
                    out_reg[e] <= 32'h7FFF_FFFF;
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            m_tdata[32*e +: 32] = out_reg[e];
        end
        for (int a = 0; a < 3; a++) begin
            m_tdata[288 + 32*a +: 32] = pos_reg[SE][a];
        end
    end

endmodule

// ===== hdl/trs_mm_assert.sv =====
// port-level assertions for trs_model_matrix, bound to the top level
// depends on trs_pkg and trs_model_matrix
module trs_mm_assert (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [trs_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import trs_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // an empty output means every stage can advance
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a full pipeline with a stalled output cannot take input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !s_tready |=> !s_tready || m_tready
            || $past(m_tready))
        else $error("input accepted into a stalled full pipeline");

endmodule

bind trs_model_matrix trs_mm_assert u_trs_mm_assert (.*);
